### src/ilcs_pkg.sv
// Package for the indexed character list store.
// Holds field widths, command and status codes, and the cell control type.
// No dependencies.
package ilcs_pkg;

  localparam int CapacityDef = 16;

  localparam int FuncW   = 4;
  localparam int ByteW   = 8;
  localparam int PosW    = 5;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  localparam logic [FuncW-1:0] FN_ADD_FRONT = 4'd0;
  localparam logic [FuncW-1:0] FN_ADD_BACK  = 4'd1;
  localparam logic [FuncW-1:0] FN_INSERT_AT = 4'd2;
  localparam logic [FuncW-1:0] FN_DEL_FRONT = 4'd3;
  localparam logic [FuncW-1:0] FN_DEL_BACK  = 4'd4;
  localparam logic [FuncW-1:0] FN_DEL_AT    = 4'd5;
  localparam logic [FuncW-1:0] FN_GET       = 4'd6;
  localparam logic [FuncW-1:0] FN_SET       = 4'd7;
  localparam logic [FuncW-1:0] FN_CLEAR     = 4'd8;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_WRITE
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [ByteW-1:0] value;
  } cell_ctrl_t;

endpackage

### src/ilcs_ctrl.sv
// Command decoder for the indexed character list store.
// Checks range and fill, picks the cell operation and the new length.
// Depends on ilcs_pkg.
module ilcs_ctrl #(
  parameter int CAPACITY = ilcs_pkg::CapacityDef,
  localparam int LenW = $clog2(CAPACITY + 1),
  localparam int CmpW = (LenW > ilcs_pkg::PosW) ? LenW : ilcs_pkg::PosW
) (
  input  logic                        en_i,
  input  logic [ilcs_pkg::FuncW-1:0]  func_i,
  input  logic [ilcs_pkg::ByteW-1:0]  value_i,
  input  logic [ilcs_pkg::PosW-1:0]   position_i,
  input  logic [LenW-1:0]             len_i,
  output ilcs_pkg::cell_ctrl_t        ctrl_o,
  output logic [CmpW-1:0]             pos_o,
  output logic [ilcs_pkg::StatusW-1:0] status_o,
  output logic [LenW-1:0]             len_d_o,
  output logic                        rd_en_o
);
  import ilcs_pkg::*;

  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] len_ext;
  logic            no_entries;
  logic            is_full;
  cell_op_e        op;

  assign pos_ext    = CmpW'(position_i);
  assign len_ext    = CmpW'(len_i);
  assign no_entries = (len_i == '0);
  assign is_full    = (len_i >= LenW'(CAPACITY));

  always_comb begin
    op       = OP_HOLD;
    pos_o    = pos_ext;
    status_o = ST_OK;
    len_d_o  = len_i;
    rd_en_o  = 1'b0;
    unique case (func_i) inside
      FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT_AT: begin
        if (func_i == FN_ADD_FRONT) begin
          pos_o = '0;
        end else if (func_i == FN_ADD_BACK) begin
          pos_o = len_ext;
        end
        // The range check wins over the full check.
        if (pos_o > len_ext) begin
          status_o = ST_RANGE;
        end else if (is_full) begin
          status_o = ST_FULL;
        end else begin
          op      = OP_INSERT;
          len_d_o = len_i + LenW'(1);
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT, FN_GET, FN_SET: begin
        if (func_i == FN_DEL_FRONT) begin
          pos_o = '0;
        end else if (func_i == FN_DEL_BACK) begin
          pos_o = len_ext - CmpW'(1);
        end
        if (no_entries) begin
          status_o = ST_EMPTY;
        end else if (pos_o >= len_ext) begin
          status_o = ST_RANGE;
        end else if (func_i == FN_GET) begin
          rd_en_o = 1'b1;
        end else if (func_i == FN_SET) begin
          op = OP_WRITE;
        end else begin
          op      = OP_DELETE;
          len_d_o = len_i - LenW'(1);
        end
      end
      FN_CLEAR: begin
        len_d_o = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl_o.op    = en_i ? op : OP_HOLD;
    ctrl_o.value = value_i;
  end

endmodule

### src/ilcs_cell.sv
// One storage cell of the indexed character list store.
// Holds a byte and takes its neighbor's byte on insert or delete.
// Depends on ilcs_pkg.
module ilcs_cell #(
  parameter int CAPACITY = ilcs_pkg::CapacityDef,
  parameter int IDX      = 0,
  localparam int LenW = $clog2(CAPACITY + 1),
  localparam int CmpW = (LenW > ilcs_pkg::PosW) ? LenW : ilcs_pkg::PosW
) (
  input  logic                       clk_i,
  input  ilcs_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CmpW-1:0]            pos_i,
  input  logic [ilcs_pkg::ByteW-1:0] left_i,
  input  logic [ilcs_pkg::ByteW-1:0] right_i,
  output logic [ilcs_pkg::ByteW-1:0] data_o,
  output logic [ilcs_pkg::ByteW-1:0] rd_o
);
  import ilcs_pkg::*;

  localparam logic [CmpW-1:0] MyIdx = CmpW'(IDX);

  logic [ByteW-1:0] data_q;
  logic [ByteW-1:0] data_d;
  logic             at_pos;
  logic             above_pos;

  assign at_pos    = (pos_i == MyIdx);
  assign above_pos = (MyIdx > pos_i);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (above_pos) begin
          data_d = left_i;
        end else if (at_pos) begin
          data_d = ctrl_i.value;
        end
      end
      OP_DELETE: begin
        if (above_pos || at_pos) begin
          data_d = right_i;
        end
      end
      OP_WRITE: begin
        if (at_pos) begin
          data_d = ctrl_i.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = at_pos ? data_q : '0;

endmodule

### src/indexed_char_list_store_top.sv
// Top level of the indexed character list store.
// Uses ilcs_pkg, ilcs_ctrl and a row of ilcs_cell.
//
//   channel | direction | handshake              | fields
//   in      | input     | in_valid_i / in_stall_o | func, value, position
//   out     | output    | out_valid_o / out_stall_i | read_byte, status, count
//
// Every command completes at the edge that accepts its word: all cells shift or write in
// parallel there, and the answer is registered at that same edge.
// A new word is taken in every cycle while the output register is empty or
// its word is being taken, so a stalled output stalls the input.
// Reset clears the length and the output valid; cell contents stay undefined
// until written.
module indexed_char_list_store_top #(
  parameter int CAPACITY = ilcs_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ilcs_pkg::FuncW-1:0]    in_func_i,
  input  logic [ilcs_pkg::ByteW-1:0]    in_value_i,
  input  logic [ilcs_pkg::PosW-1:0]     in_position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ilcs_pkg::ByteW-1:0]    out_read_byte_o,
  output logic [ilcs_pkg::StatusW-1:0]  out_status_o,
  output logic [ilcs_pkg::CountW-1:0]   out_count_o
);
  import ilcs_pkg::*;

  localparam int LenW = $clog2(CAPACITY + 1);
  localparam int CmpW = (LenW > PosW) ? LenW : PosW;

  logic                 accept;
  logic [LenW-1:0]      len_q;
  logic [LenW-1:0]      len_d;
  cell_ctrl_t           cell_ctrl;
  logic [CmpW-1:0]      eff_pos;
  logic [StatusW-1:0]   status;
  logic                 rd_en;
  logic [ByteW-1:0]     cell_data [CAPACITY];
  logic [ByteW-1:0]     cell_rd   [CAPACITY];
  logic [ByteW-1:0]     rd_byte;

  logic                 out_valid_q;
  logic [ByteW-1:0]     out_byte_q;
  logic [StatusW-1:0]   out_status_q;
  logic [CountW-1:0]    out_count_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  ilcs_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .en_i      (accept),
    .func_i    (in_func_i),
    .value_i   (in_value_i),
    .position_i(in_position_i),
    .len_i     (len_q),
    .ctrl_o    (cell_ctrl),
    .pos_o     (eff_pos),
    .status_o  (status),
    .len_d_o   (len_d),
    .rd_en_o   (rd_en)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ByteW-1:0] left;
    logic [ByteW-1:0] right;
    // The first cell never takes its left input; the last cell's right input is its own byte.
    if (i == 0) begin : g_first
      assign left = in_value_i;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ilcs_cell #(
      .CAPACITY(CAPACITY),
      .IDX     (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .pos_i  (eff_pos),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  // Only the cell at the position drives a nonzero byte.
  always_comb begin
    rd_byte = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_byte = rd_byte | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q   <= rd_en ? rd_byte : '0;
      out_status_q <= status;
      out_count_q  <= CountW'(len_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_read_byte_o = out_byte_q;
  assign out_status_o    = out_status_q;
  assign out_count_o     = out_count_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(CAPACITY))
    else $error("length exceeds capacity");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_count_o == CountW'(len_q))
    else $error("reported count differs from stored length");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cell_ctrl.op == OP_INSERT |=> len_q == $past(len_q) + LenW'(1))
    else $error("insert did not grow the list by one");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_read_byte_o != '0 |-> out_status_o == ST_OK)
    else $error("read byte given with a failing status");

endmodule

### bench/indexed_char_list_store_top_test.sv
// Self-checking testbench for indexed_char_list_store_top.
// Runs a table of directed commands and then random command bursts against a
// behavioral copy of the list. It depends on ilcs_pkg and the top level only.
`timescale 1ns / 100ps

module indexed_char_list_store_top_test;
  import ilcs_pkg::*;

  localparam int LIST_CAP     = CapacityDef;
  localparam int CELL_IDX_W   = $clog2(LIST_CAP);
  localparam int RAND_ITEMS   = 400;
  localparam int PRESSURE_AT  = 150;
  localparam int PRESSURE_CYC = 120;
  localparam int DRAIN_CYC    = 8;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int SHOW_ERRORS  = 10;

  // Command codes that the block does not define.
  localparam logic [FuncW-1:0] FN_SPARE_LO = 4'd9;
  localparam logic [FuncW-1:0] FN_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [ByteW-1:0]   read_byte;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } answer_t;

  typedef struct {
    logic [FuncW-1:0]   func;
    logic [ByteW-1:0]   value;
    logic [PosW-1:0]    pos;
    bit                 typed;
    logic [ByteW-1:0]   rd;
    logic [StatusW-1:0] st;
    logic [CountW-1:0]  cnt;
  } dir_row_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_ACCESS, MIX_FILL, MIX_NOISE} mix_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [FuncW-1:0]   in_func   = '0;
  logic [ByteW-1:0]   in_value  = '0;
  logic [PosW-1:0]    in_pos    = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [ByteW-1:0]   out_read_byte;
  logic [StatusW-1:0] out_status;
  logic [CountW-1:0]  out_count;

  // Behavioral copy of the list.
  logic [ByteW-1:0] cells [LIST_CAP];
  int               list_len = 0;

  answer_t  answer_q [$];
  int       err_cnt       = 0;
  int       cmds_accepted = 0;
  int       cycles        = 0;
  int       status_seen [4];
  int       full_hits     = 0;
  bit       calm          = 1'b0;
  bit       pressure_on   = 1'b0;
  dir_row_t dir_rows [25];

  indexed_char_list_store_top #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_func_i       (in_func),
    .in_value_i      (in_value),
    .in_position_i   (in_pos),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_read_byte_o (out_read_byte),
    .out_status_o    (out_status),
    .out_count_o     (out_count)
  );

  always #2 clk = ~clk;

  // Applies one command to the list copy and returns the answer it gives.
  function automatic answer_t apply_list_cmd(logic [FuncW-1:0] f, logic [ByteW-1:0] v,
                                             logic [PosW-1:0] p);
    answer_t a;
    int      at;
    int      i;
    a = '0;
    a.status = ST_OK;
    case (f) inside
      FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT_AT: begin
        if (f == FN_ADD_FRONT) at = 0;
        else if (f == FN_ADD_BACK) at = list_len;
        else at = int'(p);
        // The range check wins over the full check.
        if (at > list_len) begin
          a.status = ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          a.status = ST_FULL;
        end else begin
          for (i = list_len; i > at; i--) cells[i] = cells[i-1];
          cells[at] = v;
          list_len++;
          if (list_len == LIST_CAP) full_hits++;
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT: begin
        if (list_len == 0) begin
          a.status = ST_EMPTY;
        end else begin
          if (f == FN_DEL_FRONT) at = 0;
          else if (f == FN_DEL_BACK) at = list_len - 1;
          else at = int'(p);
          if (at >= list_len) begin
            a.status = ST_RANGE;
          end else begin
            for (i = at; i + 1 < list_len; i++) cells[i] = cells[i+1];
            list_len--;
          end
        end
      end
      FN_GET, FN_SET: begin
        if (list_len == 0) a.status = ST_EMPTY;
        else if (int'(p) >= list_len) a.status = ST_RANGE;
        else if (f == FN_GET) a.read_byte = cells[p[CELL_IDX_W-1:0]];
        else cells[p[CELL_IDX_W-1:0]] = v;
      end
      FN_CLEAR: list_len = 0;
      default: ;
    endcase
    a.count = list_len[CountW-1:0];
    status_seen[a.status]++;
    return a;
  endfunction

  // Mostly no pause, sometimes a short one, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one command word, waits until it is taken and records the answer
  // it must produce. Entered and left at a falling edge.
  task automatic send_cmd(logic [FuncW-1:0] f, logic [ByteW-1:0] v, logic [PosW-1:0] p,
                          bit typed, answer_t typed_ans);
    answer_t pred;
    int      gap;
    in_valid <= 1'b1;
    in_func  <= f;
    in_value <= v;
    in_pos   <= p;
    do @(posedge clk); while (in_stall);
    pred = apply_list_cmd(f, v, p);
    answer_q.push_back(typed ? typed_ans : pred);
    cmds_accepted++;
    @(negedge clk);
    gap = (calm || pressure_on) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= SHOW_ERRORS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        note_error($sformatf("unexpected word rd=%02h st=%0d cnt=%0d",
                             out_read_byte, out_status, out_count));
      end else begin
        want = answer_q.pop_front();
        if (out_read_byte !== want.read_byte || out_status !== want.status ||
            out_count !== want.count)
          note_error($sformatf("expected rd=%02h st=%0d cnt=%0d, got rd=%02h st=%0d cnt=%0d",
                               want.read_byte, want.status, want.count,
                               out_read_byte, out_status, out_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycles,
               answer_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver pacing. Once, it holds off long enough for the block to back up.
  initial begin : rx_pacing
    int  hold;
    int  free;
    bit  pressed;
    pressed = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!pressed && cmds_accepted >= PRESSURE_AT) begin
        pressed     = 1'b1;
        pressure_on = 1'b1;
        hold        = PRESSURE_CYC;
      end else begin
        hold = idle_len();
      end
      free = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall   <= 1'b0;
      pressure_on = 1'b0;
      repeat (free) @(negedge clk);
    end
  end

  initial begin : stimulus
    int               rand_sent;
    int               blen;
    int               roll;
    mix_e             kind;
    logic [FuncW-1:0] f;
    logic [ByteW-1:0] v;
    logic [PosW-1:0]  p;
    answer_t          typed_ans;

    dir_rows = '{
      // Everything that touches an entry fails on the empty list.
      '{FN_GET,       8'h00, 5'd0,  1'b1, 8'h00, ST_EMPTY, 5'd0},
      '{FN_DEL_FRONT, 8'h00, 5'd0,  1'b1, 8'h00, ST_EMPTY, 5'd0},
      '{FN_DEL_BACK,  8'h00, 5'd0,  1'b1, 8'h00, ST_EMPTY, 5'd0},
      '{FN_DEL_AT,    8'h00, 5'd0,  1'b1, 8'h00, ST_EMPTY, 5'd0},
      '{FN_SET,       8'h33, 5'd0,  1'b1, 8'h00, ST_EMPTY, 5'd0},
      '{FN_INSERT_AT, 8'h11, 5'd1,  1'b1, 8'h00, ST_RANGE, 5'd0},
      '{FN_INSERT_AT, 8'h00, 5'd0,  1'b1, 8'h00, ST_OK,    5'd1},
      '{FN_ADD_BACK,  8'hFF, 5'd0,  1'b1, 8'h00, ST_OK,    5'd2},
      '{FN_ADD_FRONT, 8'hA5, 5'd31, 1'b1, 8'h00, ST_OK,    5'd3},
      '{FN_INSERT_AT, 8'h80, 5'd3,  1'b1, 8'h00, ST_OK,    5'd4},
      '{FN_INSERT_AT, 8'h01, 5'd31, 1'b1, 8'h00, ST_RANGE, 5'd4},
      '{FN_GET,       8'h00, 5'd31, 1'b1, 8'h00, ST_RANGE, 5'd4},
      '{FN_GET,       8'h00, 5'd4,  1'b1, 8'h00, ST_RANGE, 5'd4},
      '{FN_GET,       8'h00, 5'd3,  1'b0, 8'h00, ST_OK,    5'd0},
      '{FN_SET,       8'h5A, 5'd1,  1'b0, 8'h00, ST_OK,    5'd0},
      '{FN_GET,       8'hFF, 5'd1,  1'b0, 8'h00, ST_OK,    5'd0},
      '{FN_DEL_AT,    8'h00, 5'd4,  1'b1, 8'h00, ST_RANGE, 5'd4},
      '{FN_DEL_AT,    8'h00, 5'd1,  1'b0, 8'h00, ST_OK,    5'd0},
      '{FN_DEL_BACK,  8'h00, 5'd0,  1'b0, 8'h00, ST_OK,    5'd0},
      '{FN_SPARE_LO,  8'h00, 5'd0,  1'b1, 8'h00, ST_OK,    5'd2},
      '{FN_SPARE_HI,  8'hFF, 5'd31, 1'b1, 8'h00, ST_OK,    5'd2},
      '{FN_GET,       8'h00, 5'd0,  1'b0, 8'h00, ST_OK,    5'd0},
      '{FN_CLEAR,     8'hFF, 5'd31, 1'b1, 8'h00, ST_OK,    5'd0},
      '{FN_GET,       8'h00, 5'd0,  1'b1, 8'h00, ST_EMPTY, 5'd0},
      '{FN_CLEAR,     8'h00, 5'd0,  1'b1, 8'h00, ST_OK,    5'd0}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      typed_ans = '{dir_rows[i].rd, dir_rows[i].st, dir_rows[i].cnt};
      send_cmd(dir_rows[i].func, dir_rows[i].value, dir_rows[i].pos,
               dir_rows[i].typed, typed_ans);
    end

    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 28) kind = MIX_GROW;
      else if (roll < 48) kind = MIX_SHRINK;
      else if (roll < 70) kind = MIX_ACCESS;
      else if (roll < 85) kind = MIX_FILL;
      else kind = MIX_NOISE;
      calm = ($urandom_range(0, 3) == 0);

      if (kind == MIX_FILL) begin
        // Fill to the top, then knock on the full list a few times; a
        // position past the end must still report out of range.
        while (list_len < LIST_CAP) begin
          f = FuncW'($urandom_range(FN_ADD_FRONT, FN_INSERT_AT));
          send_cmd(f, ByteW'($urandom), PosW'($urandom_range(0, list_len)), 1'b0, '0);
          rand_sent++;
        end
        repeat ($urandom_range(2, 4)) begin
          f = FuncW'($urandom_range(FN_ADD_FRONT, FN_INSERT_AT));
          send_cmd(f, ByteW'($urandom), PosW'($urandom_range(0, LIST_CAP + 1)), 1'b0, '0);
          rand_sent++;
        end
      end else begin
        blen = $urandom_range(8, 30);
        repeat (blen) begin
          roll = $urandom_range(0, 99);
          if (kind == MIX_NOISE) begin
            f = FuncW'($urandom_range(0, 15));
          end else if (roll < 70) begin
            case (kind)
              MIX_GROW:   f = FuncW'($urandom_range(FN_ADD_FRONT, FN_INSERT_AT));
              MIX_SHRINK: f = FuncW'($urandom_range(FN_DEL_FRONT, FN_DEL_AT));
              default:    f = FuncW'($urandom_range(FN_GET, FN_SET));
            endcase
          end else begin
            f = FuncW'($urandom_range(FN_ADD_FRONT, FN_CLEAR));
          end
          // Clears are kept rare so the list gets a chance to grow.
          if (f == FN_CLEAR && kind != MIX_NOISE && $urandom_range(0, 2) != 0) f = FN_GET;
          v = ByteW'($urandom);
          roll = $urandom_range(0, 99);
          if (kind == MIX_NOISE || roll < 10) p = PosW'($urandom_range(0, 31));
          else if (roll < 15) p = PosW'((list_len > 0) ? list_len - 1 : LIST_CAP);
          else p = PosW'($urandom_range(0, list_len));
          send_cmd(f, v, p, 1'b0, '0);
          rand_sent++;
        end
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Ran %0d commands: %0d ok, %0d on an empty list, %0d out of range, %0d full.",
             cmds_accepted, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], status_seen[ST_FULL]);
    $display("The list filled to %0d entries %0d times; %0d errors.", LIST_CAP, full_hits,
             err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
